// ----- rtl/hav_pkg.sv -----
// ----------------------------------------------------------------------------
// hav_pkg: shared types, constants and table functions
// Fixed-point formats, CORDIC stage records and arctangent table generation
// for the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package hav_pkg;

	localparam logic signed [33:0] TURN_PER_UNIT      = 34'sd5124095576;
	localparam logic signed [33:0] HALF_TURN_PER_UNIT = 34'sd2562047788;
	localparam logic [63:0]        INV_TWO_PI_Q64     = 64'h28BE60DB9391054A;
	localparam logic [63:0]        TWO_PI_Q61         = 64'hC90FDAA22168C235;
	localparam logic signed [63:0] GAIN_Q60           = 64'sh09B74EDA80000000;
	localparam logic [63:0]        ONE_Q62            = 64'h4000000000000000;
	localparam logic [63:0]        DIST_MAX           = 64'd2635350000;
	localparam logic [22:0]        RADIUS_RESET       = 23'd6371000;
	localparam int unsigned        SQRT_STEPS         = 32;
	localparam int unsigned        MUL_LATENCY        = 2;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
		logic [1:0]         quad;
	} rot_t;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} vec_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sqrt_t;

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] qt;
		r  = '0;
		qt = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r     = r - {1'b0, d};
				qt[i] = 1'b1;
			end
		end
		return qt;
	endfunction

	function automatic logic [63:0] atan_turns(input int unsigned idx);
		logic [63:0]  sum;
		logic [63:0]  term;
		logic [127:0] p;
		int unsigned  pw;
		logic         done;
		sum  = '0;
		done = 1'b0;
		if (idx == 0)
			return 64'h2000000000000000;
		for (int unsigned k = 0; k < 64; k++) begin
			pw = (2 * k + 1) * idx;
			if (!done && pw <= 64) begin
				term = udiv64(64'd1 << (64 - pw), 64'(2 * k + 1));
				if (k[0])
					sum = sum - term;
				else
					sum = sum + term;
			end else begin
				done = 1'b1;
			end
		end
		p = 128'(sum) * 128'(INV_TWO_PI_Q64);
		return {1'b0, p[126:64]};
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage

// ----- rtl/hav_rot_cell.sv -----
// ----------------------------------------------------------------------------
// hav_rot_cell: one rotation CORDIC iteration
// Rotates the vector towards the residual angle by one table step.
// ----------------------------------------------------------------------------
module hav_rot_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hav_pkg::rot_t d,
	output hav_pkg::rot_t q
);
	import hav_pkg::*;

	localparam logic signed [63:0] ANGLE = atan_turns(STEP);

	logic signed [63:0] dx;
	logic signed [63:0] dy;
	rot_t               cell_q;

	assign dx = d.y >>> STEP;
	assign dy = d.x >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q.quad <= d.quad;
			if (!d.z[63]) begin
				cell_q.x <= d.x - dx;
				cell_q.y <= d.y + dy;
				cell_q.z <= d.z - ANGLE;
			end else begin
				cell_q.x <= d.x + dx;
				cell_q.y <= d.y - dy;
				cell_q.z <= d.z + ANGLE;
			end
		end
	end

	assign q = cell_q;

endmodule

// ----- rtl/hav_vec_cell.sv -----
// ----------------------------------------------------------------------------
// hav_vec_cell: one vectoring CORDIC iteration
// Drives y towards zero and accumulates the angle turned through.
// ----------------------------------------------------------------------------
module hav_vec_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hav_pkg::vec_t d,
	output hav_pkg::vec_t q
);
	import hav_pkg::*;

	localparam logic signed [63:0] ANGLE = atan_turns(STEP);

	logic signed [63:0] dx;
	logic signed [63:0] dy;
	vec_t               cell_q;

	assign dx = d.y >>> STEP;
	assign dy = d.x >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (d.y > 64'sd0) begin
				cell_q.x <= d.x + dx;
				cell_q.y <= d.y - dy;
				cell_q.z <= d.z + ANGLE;
			end else begin
				cell_q.x <= d.x - dx;
				cell_q.y <= d.y + dy;
				cell_q.z <= d.z - ANGLE;
			end
		end
	end

	assign q = cell_q;

endmodule

// ----- rtl/hav_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// hav_sqrt_cell: one digit of an integer square root
// Resolves one result bit by trial subtraction.
// ----------------------------------------------------------------------------
module hav_sqrt_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  hav_pkg::sqrt_t d,
	output hav_pkg::sqrt_t q
);
	import hav_pkg::*;

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	sqrt_t       cell_q;

	assign trial = d.root + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (d.rem >= trial) begin
				cell_q.rem  <= d.rem - trial;
				cell_q.root <= (d.root >> 1) + BIT;
			end else begin
				cell_q.rem  <= d.rem;
				cell_q.root <= d.root >> 1;
			end
		end
	end

	assign q = cell_q;

endmodule

// ----- rtl/hav_mul64.sv -----
// ----------------------------------------------------------------------------
// hav_mul64: two-stage 64 x 64 unsigned multiplier
// Registers four 32 x 32 partial products, then their sum.
// ----------------------------------------------------------------------------
module hav_mul64 (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod
);
	import hav_pkg::*;

	logic [63:0]  pp00_q;
	logic [63:0]  pp01_q;
	logic [63:0]  pp10_q;
	logic [63:0]  pp11_q;
	logic [127:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_q <= a[31:0] * b[31:0];
			pp01_q <= a[31:0] * b[63:32];
			pp10_q <= a[63:32] * b[31:0];
			pp11_q <= a[63:32] * b[63:32];
			prod_q <= {64'd0, pp00_q} + ({63'd0, {1'b0, pp01_q} + {1'b0, pp10_q}} << 32)
				+ {pp11_q, 64'd0};
		end
	end

	assign prod = prod_q;

endmodule

// ----- rtl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance between two points
// Fully pipelined haversine distance in centimetres on a sphere of
// programmable radius.
// ----------------------------------------------------------------------------
// Accepts one point pair per clock and passes it through two chains of
// CORDIC_STEPS CORDIC cells in turn (sine and cosine, then atan2), a 32-cell
// square root chain and four two-stage multipliers in series. Throughput is
// one item per cycle; a stalled output holds the whole pipeline. Latitude
// and longitude are in 1e-7 degree, the radius register in metres (reset
// 6371000); the result saturates at 2635350000 cm.
module haversine_distance #(
	parameter int unsigned CORDIC_STEPS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [22:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] first_lat,
	input  logic signed [31:0] first_lon,
	input  logic signed [30:0] second_lat,
	input  logic signed [31:0] second_lon,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        distance_cm
);
	import hav_pkg::*;

	localparam int unsigned LAT = 2 * CORDIC_STEPS + SQRT_STEPS + 4 * MUL_LATENCY + 4;

	logic             en;
	logic [LAT-1:0]   vld_q;
	logic [22:0]      radius_q;
	logic [63:0]      rscale_q;

	logic [63:0]      angle_s1 [4];
	rot_t             rot_d    [4][CORDIC_STEPS+1];
	logic signed [63:0] cos1, cos2, sin1, sin2;

	logic [63:0]      m1_s2, m2_s2, mc1_s2, mc2_s2;
	logic             neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [127:0]     prod_sq, prod_p1, prod_p2, prod_tb;
	logic [63:0]      ta_s5, ta_s6, tb, hsum;
	logic [63:0]      a_s7;

	sqrt_t            sqa_d [SQRT_STEPS+1];
	sqrt_t            sqb_d [SQRT_STEPS+1];
	vec_t             vec_d [CORDIC_STEPS+1];

	logic signed [63:0] zc;
	logic [63:0]      w;
	logic [127:0]     prod_rad, prod_dist;
	logic [127:0]     total;
	logic [63:0]      dist_cm;
	logic [31:0]      dist_q;

	assign en        = ~vld_q[LAT-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			radius_q <= RADIUS_RESET;
		end else begin
			if (en)
				vld_q <= {vld_q[LAT-2:0], in_valid};
			if (cfg_wr_en)
				radius_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk)
		rscale_q <= 64'(radius_q) * 64'd100;

	// angles in binary turns
	always_ff @(posedge clk) begin
		if (en) begin
			angle_s1[0] <= 64'(65'(first_lat) * 65'(TURN_PER_UNIT));
			angle_s1[1] <= 64'(65'(second_lat) * 65'(TURN_PER_UNIT));
			angle_s1[2] <= 64'(67'(33'(second_lat) - 33'(first_lat)) * 67'(HALF_TURN_PER_UNIT));
			angle_s1[3] <= 64'(67'(33'(second_lon) - 33'(first_lon)) * 67'(HALF_TURN_PER_UNIT));
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_rot
		logic [63:0] tq;
		assign tq             = angle_s1[c] + 64'h2000000000000000;
		assign rot_d[c][0].quad = tq[63:62];
		assign rot_d[c][0].z  = $signed(angle_s1[c] - {tq[63:62], 62'd0});
		assign rot_d[c][0].x  = GAIN_Q60;
		assign rot_d[c][0].y  = '0;
		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
			hav_rot_cell #(.STEP(k)) u_cell (
				.clk (clk),
				.en  (en),
				.d   (rot_d[c][k]),
				.q   (rot_d[c][k+1])
			);
		end
	end

	function automatic logic signed [63:0] rot_cos(input rot_t r);
		case (r.quad)
			2'd0:    return r.x;
			2'd1:    return -r.y;
			2'd2:    return -r.x;
			default: return r.y;
		endcase
	endfunction

	function automatic logic signed [63:0] rot_sin(input rot_t r);
		case (r.quad)
			2'd0:    return r.y;
			2'd1:    return r.x;
			2'd2:    return -r.y;
			default: return -r.x;
		endcase
	endfunction

	assign cos1 = rot_cos(rot_d[0][CORDIC_STEPS]);
	assign cos2 = rot_cos(rot_d[1][CORDIC_STEPS]);
	assign sin1 = rot_sin(rot_d[2][CORDIC_STEPS]);
	assign sin2 = rot_sin(rot_d[3][CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2  <= mag64(sin1);
			m2_s2  <= mag64(sin2);
			mc1_s2 <= mag64(cos1);
			mc2_s2 <= mag64(cos2);
			neg_s2 <= cos1[63] ^ cos2[63];
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
			neg_s5 <= neg_s4;
			neg_s6 <= neg_s5;
			ta_s5  <= prod_sq[121:58];
			ta_s6  <= ta_s5;
		end
	end

	hav_mul64 u_mul_sq (.clk(clk), .en(en), .a(m1_s2),  .b(m1_s2), .prod(prod_sq));
	hav_mul64 u_mul_p1 (.clk(clk), .en(en), .a(mc1_s2), .b(m2_s2), .prod(prod_p1));
	hav_mul64 u_mul_p2 (.clk(clk), .en(en), .a(mc2_s2), .b(m2_s2), .prod(prod_p2));
	hav_mul64 u_mul_tb (.clk(clk), .en(en), .a(prod_p1[123:60]), .b(prod_p2[123:60]),
		.prod(prod_tb));

	assign tb = prod_tb[121:58];

	always_comb begin
		if (neg_s6)
			hsum = (ta_s6 >= tb) ? ta_s6 - tb : 64'd0;
		else
			hsum = ta_s6 + tb;
	end

	always_ff @(posedge clk) begin
		if (en)
			a_s7 <= (hsum > ONE_Q62) ? ONE_Q62 : hsum;
	end

	assign sqa_d[0].rem  = a_s7;
	assign sqa_d[0].root = '0;
	assign sqb_d[0].rem  = ONE_Q62 - a_s7;
	assign sqb_d[0].root = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		hav_sqrt_cell #(.STEP(k)) u_sqa (.clk(clk), .en(en), .d(sqa_d[k]), .q(sqa_d[k+1]));
		hav_sqrt_cell #(.STEP(k)) u_sqb (.clk(clk), .en(en), .d(sqb_d[k]), .q(sqb_d[k+1]));
	end

	assign vec_d[0].x = $signed(sqb_d[SQRT_STEPS].root << 28);
	assign vec_d[0].y = $signed(sqa_d[SQRT_STEPS].root << 28);
	assign vec_d[0].z = '0;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
		hav_vec_cell #(.STEP(k)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (vec_d[k]),
			.q   (vec_d[k+1])
		);
	end

	always_comb begin
		zc = vec_d[CORDIC_STEPS].z;
		if (zc[63])
			zc = '0;
		else if (zc > $signed(ONE_Q62))
			zc = $signed(ONE_Q62);
	end

	assign w = 64'(zc) << 1;

	hav_mul64 u_mul_rad  (.clk(clk), .en(en), .a(w), .b(TWO_PI_Q61), .prod(prod_rad));
	hav_mul64 u_mul_dist (.clk(clk), .en(en), .a(prod_rad[127:64]), .b(rscale_q),
		.prod(prod_dist));

	assign total   = prod_dist + (128'd1 << 60);
	assign dist_cm = total[124:61];

	always_ff @(posedge clk) begin
		if (en) begin
			if (total[127:96] != 32'd0 || dist_cm > DIST_MAX)
				dist_q <= DIST_MAX[31:0];
			else
				dist_q <= dist_cm[31:0];
		end
	end

	assign distance_cm = dist_q;

endmodule

// ----- tb/haversine_distance_tb.sv -----
// ----------------------------------------------------------------------------
// haversine_distance_tb: self-checking bench for the great-circle distance
// Drives point pairs through the valid/ready input channel, predicts each
// distance with a bit-exact fixed-point model kept in the bench, and compares
// every output item in order. Covers field extremes, wrapped latitudes,
// saturation, radius extremes and random traffic with gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_distance_tb;
	import hav_pkg::*;

	localparam int unsigned STEPS      = 32;
	localparam int unsigned LATENCY    = 2 * STEPS + 44;
	localparam longint      CYCLE_CAP  = 600000;
	localparam logic [63:0] TURN_UNIT  = 64'd5124095576;
	localparam logic [63:0] HALF_UNIT  = 64'd2562047788;
	localparam logic [63:0] INV_2PI    = 64'h28BE60DB9391054A;
	localparam logic [63:0] TWOPI_Q61  = 64'hC90FDAA22168C235;
	localparam logic [63:0] GAIN       = 64'h09B74EDA80000000;
	localparam logic [63:0] UNIT_Q62   = 64'h4000000000000000;
	localparam logic [63:0] SAT_CM     = 64'd2635350000;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [22:0]        cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [30:0] first_lat;
	logic signed [31:0] first_lon;
	logic signed [30:0] second_lat;
	logic signed [31:0] second_lon;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        distance_cm;

	logic [63:0] atan_tab [0:STEPS];
	logic [22:0] radius_m;
	logic [31:0] dist_q [$];
	int          fail_count;
	int          sent_count;
	int          recv_count;
	int          sat_count;
	longint      cycle_count;
	bit          gaps_on;
	int          stall_left;

	haversine_distance #(.CORDIC_STEPS(STEPS)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_lat(first_lat), .first_lon(first_lon),
		.second_lat(second_lat), .second_lon(second_lon),
		.out_valid(out_valid), .out_ready(out_ready), .distance_cm(distance_cm)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return 64'(p >> s);
	endfunction

	function automatic logic [63:0] atan_entry(int unsigned i);
		logic [63:0] sum;
		logic [63:0] term;
		int unsigned pw;
		sum = '0;
		if (i == 0)
			return 64'h2000000000000000;
		for (int unsigned k = 0; k < 64; k++) begin
			pw = (2 * k + 1) * i;
			if (pw > 64)
				break;
			term = (64'd1 << (64 - pw)) / 64'(2 * k + 1);
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		return mul_shift(sum, INV_2PI, 63) >> 1;
	endfunction

	task automatic rotate(input logic [63:0] t, output longint c, output longint s);
		logic [63:0] tt;
		logic [1:0]  q;
		longint      x, y, z, dx, dy;
		tt = t + 64'h2000000000000000;
		q  = tt[63:62];
		z  = longint'(t - {q, 62'b0});
		x  = longint'(GAIN);
		y  = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_tab[i]);
			end else begin
				x += dx; y -= dy; z += longint'(atan_tab[i]);
			end
		end
		case (q)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] res, bits;
		res  = '0;
		bits = 64'd1 << 62;
		while (bits > v)
			bits >>= 2;
		while (bits != 0) begin
			if (v >= res + bits) begin
				v   = v - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] abs64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	task automatic predict_distance(input longint lat1, input longint lon1, input longint lat2,
			input longint lon2, output logic [31:0] want_cm);
		longint       c1, c2, s1, s2, unused, x, y, z, dx, dy;
		logic [63:0]  m2, ta, tb, a, w, rad;
		logic [127:0] prod;
		rotate(64'(lat1) * TURN_UNIT, c1, unused);
		rotate(64'(lat2) * TURN_UNIT, c2, unused);
		rotate(64'(lat2 - lat1) * HALF_UNIT, unused, s1);
		rotate(64'(lon2 - lon1) * HALF_UNIT, unused, s2);
		m2 = abs64(s2);
		ta = mul_shift(abs64(s1), abs64(s1), 58);
		tb = mul_shift(mul_shift(abs64(c1), m2, 60), mul_shift(abs64(c2), m2, 60), 58);
		if ((c1 < 0) != (c2 < 0))
			a = ta >= tb ? ta - tb : 64'd0;
		else
			a = ta + tb;
		if (a > UNIT_Q62)
			a = UNIT_Q62;
		x = longint'(floor_root(UNIT_Q62 - a) << 28);
		y = longint'(floor_root(a) << 28);
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(atan_tab[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(atan_tab[i]);
			end
		end
		if (z < 0)
			z = 0;
		if (64'(z) > UNIT_Q62)
			z = longint'(UNIT_Q62);
		w    = 64'(z) << 1;
		rad  = mul_shift(w, TWOPI_Q61, 64);
		prod = 128'(rad) * 128'(64'(radius_m) * 64'd100) + (128'd1 << 60);
		prod = prod >> 61;
		want_cm = prod > 128'(SAT_CM) ? SAT_CM[31:0] : prod[31:0];
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready  <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// check each item in order
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			recv_count++;
			if (dist_q.size() == 0) begin
				$error("distance_cm: unexpected item, actual %0d", distance_cm);
				fail_count++;
			end else begin
				if (distance_cm !== dist_q[0]) begin
					$error("distance_cm: expected %0d, actual %0d", dist_q[0], distance_cm);
					fail_count++;
				end
				if (dist_q[0] == SAT_CM[31:0])
					sat_count++;
				void'(dist_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("haversine_distance_tb: errors");
			$finish;
		end
	end

	task automatic send_pair(input longint lat1, input longint lon1, input longint lat2,
			input longint lon2);
		int          gap;
		bit          taken;
		logic [31:0] want_cm;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		first_lat  <= 31'(lat1);
		first_lon  <= 32'(lon1);
		second_lat <= 31'(lat2);
		second_lon <= 32'(lon2);
		predict_distance(longint'(31'(lat1) ^ 31'h40000000) - 64'sh40000000,
			longint'(32'(lon1) ^ 32'h80000000) - 64'sh80000000,
			longint'(31'(lat2) ^ 31'h40000000) - 64'sh40000000,
			longint'(32'(lon2) ^ 32'h80000000) - 64'sh80000000, want_cm);
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			if (taken)
				dist_q = {dist_q, want_cm};
			@(posedge clk);
		end
		sent_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (dist_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_radius(input logic [22:0] r);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		radius_m = r;
	endtask

	function automatic longint rand_lat();
		return longint'($urandom_range(0, 1800000000)) - 900000000;
	endfunction

	function automatic longint rand_lon();
		return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
	endfunction

	task automatic test_directed();
		set_radius(RADIUS_RESET);
		send_pair(0, 0, 0, 0);
		send_pair(900000000, 0, -900000000, 0);
		send_pair(0, 0, 0, 1800000000);
		send_pair(0, -1800000000, 0, 1800000000);
		send_pair(-900000000, -1800000000, 900000000, 1800000000);
		send_pair(450000000, 100000000, 450000001, 100000001);
		send_pair(123456789, -987654321, 123456789, -987654321);
		send_pair(-1073741824, -2147483648, 1073741823, 2147483647);
		send_pair(1073741823, 2147483647, -1073741824, -2147483648);
		send_pair(1000000000, 0, 1000000000, 1800000000);
		send_pair(-950000000, 300000000, 920000000, -300000000);
		send_pair(1, 1, -1, -1);
		send_pair(600000000, 0, -600000000, 1800000000);
	endtask

	task automatic test_radius_extremes();
		set_radius(23'h7FFFFF);
		send_pair(0, 0, 0, 1800000000);
		send_pair(900000000, 0, -900000000, 0);
		send_pair(0, 0, 0, 900000000);
		send_pair(100, 0, 0, 0);
		set_radius(23'd1);
		send_pair(0, 0, 0, 1800000000);
		send_pair(0, 0, 10, 10);
		set_radius(23'd0);
		send_pair(0, 0, 0, 1800000000);
		send_pair(300000000, 0, -200000000, 700000000);
	endtask

	task automatic test_random_points(input int n, input bit gapped);
		gaps_on = gapped;
		for (int i = 0; i < n; i++)
			send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
		gaps_on = 1'b1;
	endtask

	task automatic test_nearby_points(input int n);
		longint lat, lon;
		for (int i = 0; i < n; i++) begin
			lat = rand_lat();
			lon = rand_lon();
			send_pair(lat, lon, lat + $urandom_range(0, 2000) - 1000,
				lon + $urandom_range(0, 20000) - 10000);
		end
	endtask

	task automatic test_full_width_fields(input int n);
		for (int i = 0; i < n; i++)
			send_pair(longint'(signed'(31'($urandom()))), longint'(signed'($urandom())),
				longint'(signed'(31'($urandom()))), longint'(signed'($urandom())));
	endtask

	task automatic test_random_radii();
		for (int r = 0; r < 4; r++) begin
			set_radius(23'($urandom()));
			test_random_points(100, r[0]);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		first_lat   = '0;
		first_lon   = '0;
		second_lat  = '0;
		second_lon  = '0;
		fail_count  = 0;
		sent_count  = 0;
		recv_count  = 0;
		sat_count   = 0;
		cycle_count = 0;
		gaps_on     = 1'b1;
		radius_m    = RADIUS_RESET;
		for (int i = 0; i <= STEPS; i++)
			atan_tab[i] = atan_entry(i);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_radius_extremes();
		set_radius(RADIUS_RESET);
		test_random_points(400, 1'b0);
		test_random_points(500, 1'b1);
		test_nearby_points(300);
		test_full_width_fields(350);
		test_random_radii();
		drain();
		$display("Covered %0d point pairs, %0d distances checked (%0d saturated),",
			sent_count, recv_count, sat_count);
		$display("over default, extreme, zero and random sphere radii.");
		if (fail_count == 0)
			$display("haversine_distance_tb: clean");
		else
			$display("haversine_distance_tb: errors");
		$finish;
	end

endmodule
